[design/slpg_pkg.sv]
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

   // base tick period in milliseconds
   localparam int unsigned TICK_MS = 10;

   localparam int unsigned MODE_W      = 3;
   localparam int unsigned MS_W        = 16;
   localparam int unsigned CNT_W       = 16;
   localparam int unsigned OVR_W       = 13;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [OVR_W-1:0] OVR_MAX = {OVR_W{1'b1}};

   // ms to ticks: multiply by a rounded-up reciprocal, exact for any MS_W-bit value
   localparam int unsigned DIV_SHIFT = MS_W + $clog2(TICK_MS);
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + TICK_MS - 1) / TICK_MS;
   localparam int unsigned RECIP_W = MS_W + 1;
   localparam int unsigned PROD_W  = MS_W + RECIP_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF         = 3'd0,
      MODE_ON          = 3'd1,
      MODE_SLOW_BLINK  = 3'd2,
      MODE_FAST_BLINK  = 3'd3,
      MODE_FAST_STROBE = 3'd4,
      MODE_SLOW_STROBE = 3'd5
   } mode_type;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_BLINK_TICKS        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_BLINK_TICKS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_STROBE_PERIOD      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_STROBE_WINDOW      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_STROBE_PERIOD      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_STROBE_WINDOW      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_STROBE_BLINK_TICKS = 3'd6;

endpackage

[design/status_led_pattern_generator.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Tick-driven LED pattern generator with modes, strobes and a blink override.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one transfer per base tick, optionally carrying a new mode
//   and an override duration in milliseconds (converted to ticks on entry).
//   rsp_ channel: exactly one transfer per request, the LED level and the
//   override flag after that tick, in request order.
//   csr_ channel: register writes, always ready; write only while idle.
//   Result path: a request passes through the input register, then the tick
//   logic into the result register.
//   Throughput: one request per cycle while the receiver takes results; the
//   per-tick compare/decrement logic between the two registers sets this.
//   Receiver stall: the result register holds, one more request is taken into
//   the input register, then req_ready drops until the result is taken.
//   Reset: all modes and countdowns clear, the LED is off and the registers
//   return to their default pattern timings.
// ----------------------------------------------------------------------------
module status_led_pattern_generator (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_mode_valid,
   input  logic [slpg_pkg::MODE_W-1:0]               req_new_mode,
   input  logic                                      req_override_valid,
   input  logic [slpg_pkg::MS_W-1:0]                 req_override_ms,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_led_on,
   output logic                                      rsp_override_active,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [slpg_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [slpg_pkg::CSR_DATA_W-1:0]           csr_data
);
   import slpg_pkg::*;

   // configuration
   logic [CNT_W-1:0] slow_blink_ff, fast_blink_ff, fs_period_ff, fs_window_ff;
   logic [CNT_W-1:0] ss_period_ff, ss_window_ff, ss_blink_ff;

   // input register
   logic             s1_valid_ff;
   logic             s1_mode_valid_ff;
   logic [MODE_W-1:0] s1_new_mode_ff;
   logic             s1_ovr_valid_ff;
   logic [OVR_W-1:0] s1_ovr_ticks_ff;

   // tick state
   logic [MODE_W-1:0] stored_mode_ff, stored_mode_in;
   logic [MODE_W-1:0] prev_mode_ff, prev_mode_in;
   logic             led_ff, led_in;
   logic [CNT_W-1:0] blink_ff, blink_in;
   logic [CNT_W-1:0] period_ff, period_in;
   logic [OVR_W-1:0] ovr_ff, ovr_in;

   // result register
   logic rsp_valid_ff, rsp_led_ff, rsp_ovr_ff;

   logic advance, req_xfer, tick;
   logic [PROD_W-1:0] prod;
   logic [MS_W-1:0]   quot;
   logic [OVR_W-1:0]  ovr_ticks;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;
   assign tick      = s1_valid_ff && advance;
   assign csr_ready = 1'b1;

   // ms to ticks with saturation
   always_comb begin
      prod      = PROD_W'(req_override_ms) * PROD_W'(DIV_RECIP);
      quot      = MS_W'(prod >> DIV_SHIFT);
      ovr_ticks = (quot > MS_W'(OVR_MAX)) ? OVR_MAX : quot[OVR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_xfer) begin
         s1_mode_valid_ff <= req_mode_valid;
         s1_new_mode_ff   <= req_new_mode;
         s1_ovr_valid_ff  <= req_override_valid;
         s1_ovr_ticks_ff  <= ovr_ticks;
      end
   end

   // per-tick logic
   logic [MODE_W-1:0] mode_sel, eff_mode;
   logic [OVR_W-1:0]  ovr_load;
   logic [CNT_W-1:0]  blink_dec, period_dec, blink_a, period_a, period_r;
   logic [CNT_W-1:0]  st_period, st_window, st_reload;
   logic              ovr_on, changed;

   always_comb begin
      mode_sel  = s1_mode_valid_ff ? s1_new_mode_ff : stored_mode_ff;
      ovr_load  = s1_ovr_valid_ff ? s1_ovr_ticks_ff : ovr_ff;
      ovr_in    = (ovr_load != '0) ? ovr_load - OVR_W'(1) : ovr_load;
      blink_dec = (blink_ff != '0) ? blink_ff - CNT_W'(1) : blink_ff;
      period_dec = (period_ff != '0) ? period_ff - CNT_W'(1) : period_ff;
      ovr_on    = ovr_in != '0;
      eff_mode  = ovr_on ? MODE_W'(MODE_FAST_BLINK) : mode_sel;
      changed   = eff_mode != prev_mode_ff;
      blink_a   = changed ? '0 : blink_dec;
      period_a  = changed ? '0 : period_dec;

      // strobe timing follows the selected strobe mode
      if (eff_mode == MODE_W'(MODE_FAST_STROBE)) begin
         st_period = fs_period_ff;
         st_window = fs_window_ff;
         st_reload = fast_blink_ff;
      end else begin
         st_period = ss_period_ff;
         st_window = ss_window_ff;
         st_reload = ss_blink_ff;
      end
      period_r = (period_a == '0 || period_a >= st_period) ? st_period : period_a;

      stored_mode_in = mode_sel;
      prev_mode_in   = eff_mode;
      blink_in       = blink_a;
      period_in      = period_a;
      led_in         = led_ff;

      case (mode_type'(eff_mode))
         MODE_ON: begin
            led_in = 1'b1;
         end
         MODE_SLOW_BLINK: begin
            if (blink_a == '0) begin
               blink_in = slow_blink_ff;
               led_in   = !led_ff;
            end
         end
         MODE_FAST_BLINK: begin
            if (blink_a == '0) begin
               blink_in = fast_blink_ff;
               led_in   = !led_ff;
            end
         end
         MODE_FAST_STROBE, MODE_SLOW_STROBE: begin
            period_in = period_r;
            if (period_r <= st_window) begin
               if (blink_a == '0) begin
                  blink_in = st_reload;
                  led_in   = !led_ff;
               end
            end else begin
               led_in = 1'b0;
            end
         end
         default: begin
            led_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_mode_ff <= MODE_W'(MODE_OFF);
         prev_mode_ff   <= MODE_W'(MODE_OFF);
         led_ff         <= 1'b0;
         blink_ff       <= '0;
         period_ff      <= '0;
         ovr_ff         <= '0;
      end else if (tick) begin
         stored_mode_ff <= stored_mode_in;
         prev_mode_ff   <= prev_mode_in;
         led_ff         <= led_in;
         blink_ff       <= blink_in;
         period_ff      <= period_in;
         ovr_ff         <= ovr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (tick) begin
         rsp_led_ff <= led_in;
         rsp_ovr_ff <= ovr_on;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_led_on          = rsp_led_ff;
   assign rsp_override_active = rsp_ovr_ff;

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_blink_ff <= CNT_W'(35);
         fast_blink_ff <= CNT_W'(5);
         fs_period_ff  <= CNT_W'(100);
         fs_window_ff  <= CNT_W'(25);
         ss_period_ff  <= CNT_W'(50);
         ss_window_ff  <= CNT_W'(10);
         ss_blink_ff   <= CNT_W'(10);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLOW_BLINK_TICKS:        slow_blink_ff <= csr_data;
            CSR_FAST_BLINK_TICKS:        fast_blink_ff <= csr_data;
            CSR_FAST_STROBE_PERIOD:      fs_period_ff  <= csr_data;
            CSR_FAST_STROBE_WINDOW:      fs_window_ff  <= csr_data;
            CSR_SLOW_STROBE_PERIOD:      ss_period_ff  <= csr_data;
            CSR_SLOW_STROBE_WINDOW:      ss_window_ff  <= csr_data;
            CSR_SLOW_STROBE_BLINK_TICKS: ss_blink_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule
